[src/assert_macros.svh]
// Assertion macros shared by the RTL of the PID unit.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[src/cpid_pkg.sv]
// Package of the clamped PID unit: field widths, register indexes, reset values.
// No dependencies.
package cpid_pkg;

	localparam int unsigned MeasW   = 16;
	localparam int unsigned ErrW    = MeasW + 1;
	localparam int unsigned DiffW   = ErrW + 1;
	localparam int unsigned GainW   = 24;
	localparam int unsigned LimW    = 15;
	localparam int unsigned PeriodW = 8;
	localparam int unsigned DriveW  = 16;
	localparam int unsigned IntegW  = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 24;
	localparam int unsigned FracW   = 8;
	localparam int unsigned SumW    = 44;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_SETPOINT    = 3'd3,
		REG_DRIVE_LIM   = 3'd4,
		REG_INTEG_LIM   = 3'd5,
		REG_INTEG_PER   = 3'd6
	} cfg_reg_t;

	localparam logic signed [GainW-1:0]  GainPRst   = -24'sd5901;
	localparam logic signed [GainW-1:0]  GainIRst   = -24'sd95;
	localparam logic signed [GainW-1:0]  GainDRst   = 24'sd333;
	localparam logic signed [MeasW-1:0]  SetpointRst = 16'sd30;
	localparam logic [LimW-1:0]          DriveLimRst = 15'd150;
	localparam logic [LimW-1:0]          IntegLimRst = 15'd50;
	localparam logic [PeriodW-1:0]       PeriodRst   = 8'd0;

endpackage

[src/clamped_pid_with_decimated_integral_unit.sv]
// Clamped PID unit with decimated, clamped integral (top level).
// Depends on cpid_pkg and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid, in_stall, measured): one sample per word.
//  - Output channel (out_valid, out_stall, drive): one drive word per sample,
//    in order. drive = clamp(trunc0((Kp*e + Kd*de + Ki*I) / 256), +/-drive_limit).
//  - Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
//    always high; index 0..6 selects gain_p, gain_i, gain_d, setpoint,
//    drive_limit, integral_limit, integrate_period; other indexes are dropped.
//    Write only while no sample is in flight.
//  - Throughput: one sample per cycle while the output is not stalled; three
//    register stages (input, products, output) each hand on a word every cycle
//    unless stalled. Error, integral and decimation state update as a sample
//    leaves the input stage. A stalled output holds its word; stages behind it
//    keep filling, and in_stall rises only once all three stages hold words.
//  - Reset clears the pipeline, error history, integral and decimation count,
//    and loads the register defaults.
`include "assert_macros.svh"

module clamped_pid_with_decimated_integral_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [cpid_pkg::MeasW-1:0]      measured,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [cpid_pkg::DriveW-1:0]     drive,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [cpid_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [cpid_pkg::CfgDatW-1:0]           cfg_data
);

	localparam int unsigned PW = cpid_pkg::GainW + cpid_pkg::ErrW;
	localparam int unsigned DW = cpid_pkg::GainW + cpid_pkg::DiffW;
	localparam int unsigned IW = cpid_pkg::GainW + cpid_pkg::IntegW;
	localparam int unsigned QW = cpid_pkg::SumW - cpid_pkg::FracW;

	// configuration registers
	logic signed [cpid_pkg::GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic signed [cpid_pkg::MeasW-1:0]  setpoint_q;
	logic [cpid_pkg::LimW-1:0]          drive_lim_q, integ_lim_q;
	logic [cpid_pkg::PeriodW-1:0]       period_q;

	// loop state
	logic signed [cpid_pkg::ErrW-1:0]    prev_err_q;
	logic signed [cpid_pkg::IntegW-1:0]  integ_q;
	logic [cpid_pkg::PeriodW-1:0]        dec_cnt_q;

	// pipeline
	logic                                v_s1, v_s2;
	logic signed [cpid_pkg::MeasW-1:0]   meas_s1;
	logic signed [PW-1:0]                prod_p_s2;
	logic signed [DW-1:0]                prod_d_s2;
	logic signed [IW-1:0]                prod_i_s2;

	logic en_out, en2, adv1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= cpid_pkg::GainPRst;
			gain_i_q    <= cpid_pkg::GainIRst;
			gain_d_q    <= cpid_pkg::GainDRst;
			setpoint_q  <= cpid_pkg::SetpointRst;
			drive_lim_q <= cpid_pkg::DriveLimRst;
			integ_lim_q <= cpid_pkg::IntegLimRst;
			period_q    <= cpid_pkg::PeriodRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cpid_pkg::cfg_reg_t'(cfg_index))
				cpid_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data[cpid_pkg::GainW-1:0];
				cpid_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data[cpid_pkg::GainW-1:0];
				cpid_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data[cpid_pkg::GainW-1:0];
				cpid_pkg::REG_SETPOINT:  setpoint_q  <= cfg_data[cpid_pkg::MeasW-1:0];
				cpid_pkg::REG_DRIVE_LIM: drive_lim_q <= cfg_data[cpid_pkg::LimW-1:0];
				cpid_pkg::REG_INTEG_LIM: integ_lim_q <= cfg_data[cpid_pkg::LimW-1:0];
				cpid_pkg::REG_INTEG_PER: period_q    <= cfg_data[cpid_pkg::PeriodW-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves on when the one ahead is empty or moving
	assign en_out   = !out_valid || !out_stall;
	assign en2      = !v_s2 || en_out;
	assign adv1     = v_s1 && en2;
	assign in_stall = v_s1 && !en2;

	// error, difference and integral from the word in stage 1
	logic signed [cpid_pkg::ErrW-1:0]    err;
	logic signed [cpid_pkg::DiffW-1:0]   diff;
	logic signed [cpid_pkg::DiffW-1:0]   acc, lim_pos, lim_neg;
	logic signed [cpid_pkg::IntegW-1:0]  integ_new, integ_use;
	logic                                integrate;

	always_comb begin
		err      = {meas_s1[cpid_pkg::MeasW-1], meas_s1}
		         - {setpoint_q[cpid_pkg::MeasW-1], setpoint_q};
		diff     = {err[cpid_pkg::ErrW-1], err} - {prev_err_q[cpid_pkg::ErrW-1], prev_err_q};
		acc      = {{2{integ_q[cpid_pkg::IntegW-1]}}, integ_q} + {err[cpid_pkg::ErrW-1], err};
		lim_pos  = {3'b000, integ_lim_q};
		lim_neg  = -lim_pos;
		if (acc > lim_pos) begin
			integ_new = lim_pos[cpid_pkg::IntegW-1:0];
		end else if (acc < lim_neg) begin
			integ_new = lim_neg[cpid_pkg::IntegW-1:0];
		end else begin
			integ_new = acc[cpid_pkg::IntegW-1:0];
		end
		integrate = dec_cnt_q >= period_q;
		integ_use = integrate ? integ_new : integ_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			prev_err_q <= '0;
			integ_q    <= '0;
			dec_cnt_q  <= '0;
		end else begin
			if (!in_stall) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (adv1) begin
				prev_err_q <= err;
				integ_q    <= integ_use;
				dec_cnt_q  <= integrate ? '0 : dec_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			meas_s1 <= measured;
		end
		if (adv1) begin
			prod_p_s2 <= PW'(gain_p_q) * PW'(err);
			prod_d_s2 <= DW'(gain_d_q) * DW'(diff);
			prod_i_s2 <= IW'(gain_i_q) * IW'(integ_use);
		end
	end

	// sum, divide by 256 toward zero, saturate
	logic signed [cpid_pkg::SumW-1:0]   sum, sum_b;
	logic signed [QW-1:0]               quot, dlim_pos, dlim_neg;
	logic signed [cpid_pkg::DriveW-1:0] drive_d;

	always_comb begin
		sum   = cpid_pkg::SumW'(prod_p_s2) + cpid_pkg::SumW'(prod_d_s2)
		      + cpid_pkg::SumW'(prod_i_s2);
		// bias negative sums so the shift rounds toward zero
		sum_b = sum + (sum[cpid_pkg::SumW-1] ? cpid_pkg::SumW'(255) : '0);
		quot  = sum_b[cpid_pkg::SumW-1:cpid_pkg::FracW];
		dlim_pos = {{(QW-cpid_pkg::LimW){1'b0}}, drive_lim_q};
		dlim_neg = -dlim_pos;
		if (quot > dlim_pos) begin
			drive_d = dlim_pos[cpid_pkg::DriveW-1:0];
		end else if (quot < dlim_neg) begin
			drive_d = dlim_neg[cpid_pkg::DriveW-1:0];
		end else begin
			drive_d = quot[cpid_pkg::DriveW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			drive <= drive_d;
		end
	end

	`ASSERT_IMPLY(a_drive_in_bound, clk, arst_n, out_valid,
		(drive <= $signed({1'b0, drive_lim_q})) && (drive >= -$signed({1'b0, drive_lim_q})),
		"drive word outside the drive limit")
	`ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, in_stall,
		v_s1 && v_s2 && out_valid && out_stall, "input stalled with a free stage")
	`ASSERT_NEXT(a_decim_wraps, clk, arst_n, adv1 && (dec_cnt_q >= period_q),
		dec_cnt_q == '0, "decimation count not restarted after integrating")

endmodule

[test/tb_top.sv]
// Self-checking bench of the clamped PID unit: drives measured samples and register
// writes; checks each drive word against a table value or a built-in control-law model.
// Depends on cpid_pkg and clamped_pid_with_decimated_integral_unit.
module tb_top;
	import cpid_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
	localparam logic IsWrite = 1'b1;
	localparam logic IsSample = 1'b0;
	localparam logic Typed = 1'b1;
	localparam logic Pred = 1'b0;

	typedef struct packed {
		logic                      is_write;
		logic [CfgIdxW-1:0]        idx;
		logic [CfgDatW-1:0]        data;
		logic signed [MeasW-1:0]   meas;
		logic                      given;
		logic signed [DriveW-1:0]  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [MeasW-1:0] measured = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DriveW-1:0] drive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDatW-1:0] cfg_data = '0;

	// register copies and control state of the model
	logic signed [GainW-1:0] kp, ki, kd;
	logic signed [MeasW-1:0] sp;
	logic [LimW-1:0] drive_lim, integ_lim;
	logic [PeriodW-1:0] integ_per;
	logic signed [ErrW-1:0] prev_err;
	logic signed [IntegW-1:0] integ;
	logic [PeriodW-1:0] integ_count;

	logic signed [DriveW-1:0] drive_due [$];
	logic signed [DriveW-1:0] due_word;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned hold = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	dir_row_t dir_rows [45] = '{
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd30, Typed, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Typed, -16'sd150},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h8000, Typed, 16'sd150},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd30, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, -16'sd1, Pred, 16'sd0},
		'{IsWrite, REG_DRIVE_LIM, 24'd0, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd12345, Typed, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h8000, Typed, 16'sd0},
		'{IsWrite, REG_DRIVE_LIM, 24'hFF7FFF, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_P, 24'h7FFFFF, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_I, 24'h800000, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_D, 24'd0, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Typed, 16'sd32767},
		'{IsWrite, REG_GAIN_P, 24'h800000, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Typed, -16'sd32767},
		'{IsWrite, REG_INTEG_LIM, 24'd0, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_P, 24'd0, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_I, 24'd256, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h8000, Typed, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Typed, 16'sd0},
		'{IsWrite, REG_INTEG_LIM, 24'h007FFF, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_I, 24'd1, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_D, 24'd256, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_INTEG_PER, 24'd3, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd100, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, -16'sd200, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd300, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Pred, 16'sd0},
		'{IsWrite, REG_INTEG_PER, 24'd255, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd1, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd2, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd3, Pred, 16'sd0},
		// period now below the count: next sample integrates straight away
		'{IsWrite, REG_INTEG_PER, 24'd1, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd4, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd5, Pred, 16'sd0},
		'{IsWrite, RegUnused, 24'h123456, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'sd6, Pred, 16'sd0},
		'{IsWrite, REG_SETPOINT, 24'hFF8000, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Pred, 16'sd0},
		'{IsWrite, REG_SETPOINT, 24'h007FFF, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h8000, Pred, 16'sd0},
		'{IsWrite, REG_GAIN_D, 24'h800000, 16'sd0, Pred, 16'sd0},
		'{IsWrite, REG_INTEG_LIM, 24'hFF8000, 16'sd0, Pred, 16'sd0},
		'{IsSample, REG_GAIN_P, 24'd0, 16'h7FFF, Pred, 16'sd0}
	};

	clamped_pid_with_decimated_integral_unit DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [DriveW-1:0] predict_drive(
		input logic signed [MeasW-1:0] meas
	);
		int err, diff, acc;
		longint total, quot;
		err = int'(meas) - int'(sp);
		diff = err - int'(prev_err);
		if (integ_count >= integ_per) begin
			acc = int'(integ) + err;
			if (acc < -int'(integ_lim))
				acc = -int'(integ_lim);
			if (acc > int'(integ_lim))
				acc = int'(integ_lim);
			integ = acc[IntegW-1:0];
			integ_count = '0;
		end else begin
			integ_count = integ_count + 1'b1;
		end
		total = longint'(kp) * err + longint'(kd) * diff + longint'(ki) * int'(integ);
		quot = total / 256; // truncates toward zero
		if (quot > longint'(drive_lim))
			quot = longint'(drive_lim);
		if (quot < -longint'(drive_lim))
			quot = -longint'(drive_lim);
		prev_err = err[ErrW-1:0];
		return quot[DriveW-1:0];
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_GAIN_P: kp = data;
		REG_GAIN_I: ki = data;
		REG_GAIN_D: kd = data;
		REG_SETPOINT: sp = data[MeasW-1:0];
		REG_DRIVE_LIM: drive_lim = data[LimW-1:0];
		REG_INTEG_LIM: integ_lim = data[LimW-1:0];
		REG_INTEG_PER: integ_per = data[PeriodW-1:0];
		default: ;
		endcase
	endtask

	task automatic send_sample(
		input logic signed [MeasW-1:0] meas,
		input logic given,
		input logic signed [DriveW-1:0] want
	);
		int unsigned gap;
		logic signed [DriveW-1:0] pred;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if (cfg_valid)
			cfg_valid <= 1'b0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		measured <= meas;
		do @(posedge clk); while (in_stall);
		pred = predict_drive(meas);
		drive_due.push_back(given ? want : pred);
	endtask

	// hold off the sender until every drive word is back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (drive_due.size() != 0);
	endtask

	initial begin
		logic [CfgDatW-1:0] word;
		logic signed [MeasW-1:0] m;
		kp = GainPRst;
		ki = GainIRst;
		kd = GainDRst;
		sp = SetpointRst;
		drive_lim = DriveLimRst;
		integ_lim = IntegLimRst;
		integ_per = PeriodRst;
		prev_err = '0;
		integ = '0;
		integ_count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_write) begin
				if (in_valid)
					settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_sample(dir_rows[i].meas, dir_rows[i].given, dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			for (int r = 0; r < 7; r++) begin
				word = 24'($urandom);
				case (r)
				REG_GAIN_P, REG_GAIN_I, REG_GAIN_D:
					case ($urandom_range(0, 5))
					0: word = 24'h800000;
					1: word = 24'h7FFFFF;
					2: word = '0;
					3, 4: word = 24'(int'($urandom_range(0, 4096)) - 2048);
					default: ;
					endcase
				REG_SETPOINT:
					if ($urandom_range(0, 1))
						word[MeasW-1:0] = 16'($urandom_range(0, 200)) - 16'd100;
				REG_DRIVE_LIM, REG_INTEG_LIM:
					case ($urandom_range(0, 4))
					0: word[LimW-1:0] = '0;
					1: word[LimW-1:0] = '1;
					2, 3: word[LimW-1:0] = 15'($urandom_range(0, 2000));
					default: ;
					endcase
				REG_INTEG_PER:
					case ($urandom_range(0, 3))
					0: word[PeriodW-1:0] = '0;
					1: word[PeriodW-1:0] = '1;
					2: word[PeriodW-1:0] = 8'($urandom_range(1, 5));
					default: ;
					endcase
				default: ;
				endcase
				write_reg(r[CfgIdxW-1:0], word);
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(RegUnused, 24'($urandom));

			for (int k = 0; k < 200; k++) begin
				if (k % 50 == 0) begin
					tx_calm = ($urandom_range(0, 3) == 0);
					rx_calm = ($urandom_range(0, 3) == 0);
				end
				if (ph == 3 && k == 100)
					settle();
				// half the time near the setpoint, so the output is not always pinned
				case ($urandom_range(0, 7))
				0: m = 16'h7FFF;
				1: m = 16'h8000;
				2, 3: m = 16'($urandom);
				default: m = sp + 16'($urandom_range(0, 512)) - 16'sd256;
				endcase
				send_sample(m, Pred, '0);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// drive word checker and random output stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (drive_due.size() == 0) begin
					$display("%0t: drive word %0d with no sample pending", $time, drive);
					mismatches++;
				end else begin
					due_word = drive_due.pop_front();
					if (drive !== due_word) begin
						$display("%0t: drive mismatch, expected %0d, got %0d",
							$time, due_word, drive);
						mismatches++;
					end
				end
				hold = rx_calm ? 0 : $urandom_range(0, 6);
			end else if (hold != 0) begin
				hold--;
			end
			out_stall <= (hold != 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
